/* sv/sha1_pkg.sv */
// shared types, constants and round functions of the sha-1 engine
package sha1_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_e;

  localparam int unsigned RndW = 7;
  localparam int unsigned PosW = 6;
  localparam int unsigned LenW = 64;

  localparam logic [RndW-1:0] LAST_ROUND = 7'd79;
  localparam logic [PosW-1:0] FULL_POS   = 6'd63;
  localparam logic [PosW-1:0] LEN_POS    = 6'd56;
  localparam logic [7:0]      PAD_BYTE   = 8'h80;
  localparam logic [7:0]      ZERO_BYTE  = 8'h00;

  // initial hash words
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  // round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // controls towards the schedule window
  typedef struct packed {
    logic            wr_byte;
    logic [7:0]      byte_val;
    logic [PosW-1:0] pos;
    logic            wr_len;
    logic [LenW-1:0] len;
    logic            shift;
  } sched_ctrl_t;

  // controls towards the round unit
  typedef struct packed {
    logic            load;
    logic            step;
    logic            add;
    logic            reinit;
    logic [RndW-1:0] rnd;
  } round_ctrl_t;

  // boolean function of the round group
  function automatic logic [31:0] round_f(logic [RndW-1:0] rnd, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (rnd < 7'd40 || rnd >= 7'd60) begin
      res = b ^ c ^ d;
    end else begin
      res = (b & c) | (b & d) | (c & d);
    end
    return res;
  endfunction

  // additive constant of the round group
  function automatic logic [31:0] round_k(logic [RndW-1:0] rnd);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = K0;
    end else if (rnd < 7'd40) begin
      res = K1;
    end else if (rnd < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

/* sv/sha1_if.sv */
// handshake channels for message bytes and digests

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;

  modport source(output valid, output data_byte, output byte_present, output last_byte,
                 input ready);
  modport sink(input valid, input data_byte, input byte_present, input last_byte,
               output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  modport source(output valid, output digest_word0, output digest_word1,
                 output digest_word2, output digest_word3, output digest_word4,
                 input ready);
  modport sink(input valid, input digest_word0, input digest_word1,
               input digest_word2, input digest_word3, input digest_word4,
               output ready);
endinterface

/* sv/sha1_sched.sv */
// 16-word block buffer that doubles as the message schedule shift window
module sha1_sched (
  input  logic                  clk_i,
  input  sha1_pkg::sched_ctrl_t ctrl_i,
  output logic [31:0]           w_o
);

  logic [31:0] win_q [16];
  logic [31:0] mix;
  logic [31:0] w_new;
  logic [3:0]  word_idx;
  logic [4:0]  lane_off;

  // next schedule word, sixteen words ahead of the current one
  assign mix      = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign w_new    = {mix[30:0], mix[31]};
  assign word_idx = ctrl_i.pos[5:2];
  assign lane_off = {~ctrl_i.pos[1:0], 3'b000};
  assign w_o      = win_q[0];

  // byte packing, length words and window shift
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= w_new;
    end else begin
      if (ctrl_i.wr_byte) begin
        if (ctrl_i.pos[1:0] == 2'd0) begin
          win_q[word_idx] <= {ctrl_i.byte_val, 24'd0};
        end else begin
          win_q[word_idx][lane_off +: 8] <= ctrl_i.byte_val;
        end
      end
      if (ctrl_i.wr_len) begin
        win_q[14] <= ctrl_i.len[63:32];
        win_q[15] <= ctrl_i.len[31:0];
      end
    end
  end

endmodule

/* sv/sha1_round.sv */
// shared round unit: working registers, one round per cycle, chaining values
module sha1_round (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1_pkg::round_ctrl_t ctrl_i,
  input  logic [31:0]           w_i,
  output logic [4:0][31:0]      chain_o
);

  logic [4:0][31:0] wk_q;
  logic [4:0][31:0] chain_q;
  logic [31:0]      tmp;
  logic [31:0]      fval;

  // one round of the compression function
  assign fval = sha1_pkg::round_f(ctrl_i.rnd, wk_q[1], wk_q[2], wk_q[3]);
  assign tmp  = {wk_q[0][26:0], wk_q[0][31:27]} + fval + wk_q[4]
              + sha1_pkg::round_k(ctrl_i.rnd) + w_i;

  // working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      wk_q <= chain_q;
    end else if (ctrl_i.step) begin
      wk_q[0] <= tmp;
      wk_q[1] <= wk_q[0];
      wk_q[2] <= {wk_q[1][1:0], wk_q[1][31:2]};
      wk_q[3] <= wk_q[2];
      wk_q[4] <= wk_q[3];
    end
  end

  // chaining values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= {sha1_pkg::IV4, sha1_pkg::IV3, sha1_pkg::IV2, sha1_pkg::IV1, sha1_pkg::IV0};
    end else if (ctrl_i.reinit) begin
      chain_q <= {sha1_pkg::IV4, sha1_pkg::IV3, sha1_pkg::IV2, sha1_pkg::IV1, sha1_pkg::IV0};
    end else if (ctrl_i.add) begin
      for (int i = 0; i < 5; i++) begin
        chain_q[i] <= chain_q[i] + wk_q[i];
      end
    end
  end

  assign chain_o = chain_q;

  // the chaining values are only updated while no round is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step |=> $stable(chain_q) || $past(ctrl_i.add) || $past(ctrl_i.reinit))
    else $error("chain values changed during a round");

  // a load never coincides with a round step
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ctrl_i.load && ctrl_i.step))
    else $error("load and round step together");

  // addition never coincides with a round step
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ctrl_i.add && ctrl_i.step))
    else $error("chain add during a round");

endmodule

/* sv/sha1_hash_engine.sv */
// sha-1 hash engine top level: byte intake, padding sequencer and digest output
// one message byte is taken per cycle while idle; a byte that fills a 64-byte block
// starts the rounds through the shared round unit, then the chain add (load goes with it)
// on the last byte, padding writes one byte per cycle up to the length slot,
// then one or two compressions run and the emit state loads the digest
// the digest register lets the next message start while a digest waits
// reset sets the initial hash words and clears counters; the block buffer is not cleared
module sha1_hash_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  sha1_in_if.sink          msg_i,
  sha1_out_if.source       dig_o
);

  sha1_pkg::state_e                  state_q, state_d;
  logic [sha1_pkg::PosW-1:0]         pos_q, pos_d;
  logic [sha1_pkg::LenW-1:0]         len_q, len_d;
  logic [sha1_pkg::RndW-1:0]         rnd_q, rnd_d;
  logic                              last_pend_q, last_pend_d;
  logic                              pad_first_q, pad_first_d;
  logic                              final_q, final_d;
  logic                              out_valid_q;
  logic [4:0][31:0]                  digest_q;
  logic [4:0][31:0]                  chain;
  logic [31:0]                       w;
  logic                              in_fire;
  logic                              emit;
  sha1_pkg::sched_ctrl_t             sc;
  sha1_pkg::round_ctrl_t             rc;

  assign msg_i.ready = (state_q == sha1_pkg::ST_IDLE);
  assign in_fire     = msg_i.valid && (state_q == sha1_pkg::ST_IDLE);

  sha1_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sc),
    .w_o    (w)
  );

  sha1_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rc),
    .w_i     (w),
    .chain_o (chain)
  );

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha1_pkg::ST_IDLE;
      pos_q       <= '0;
      len_q       <= '0;
      rnd_q       <= '0;
      last_pend_q <= 1'b0;
      pad_first_q <= 1'b0;
      final_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      rnd_q       <= rnd_d;
      last_pend_q <= last_pend_d;
      pad_first_q <= pad_first_d;
      final_q     <= final_d;
    end
  end

  // next state and unit controls
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    len_d       = len_q;
    rnd_d       = rnd_q;
    last_pend_d = last_pend_q;
    pad_first_d = pad_first_q;
    final_d     = final_q;
    emit        = 1'b0;
    sc          = '0;
    sc.pos      = pos_q;
    sc.len      = len_q;
    rc          = '0;
    rc.rnd      = rnd_q;
    unique case (state_q)
      sha1_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (msg_i.byte_present) begin
            sc.wr_byte  = 1'b1;
            sc.byte_val = msg_i.data_byte;
            pos_d       = pos_q + 6'd1;
            len_d       = len_q + 64'd8;
          end
          if (msg_i.last_byte) begin
            last_pend_d = 1'b1;
            pad_first_d = 1'b1;
          end
          if (msg_i.byte_present && pos_q == sha1_pkg::FULL_POS) begin
            rc.load = 1'b1;
            state_d = sha1_pkg::ST_ROUND;
          end else if (msg_i.last_byte) begin
            state_d = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_ROUND: begin
        sc.shift = 1'b1;
        rc.step  = 1'b1;
        if (rnd_q == sha1_pkg::LAST_ROUND) begin
          rnd_d   = '0;
          state_d = sha1_pkg::ST_ADD;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      sha1_pkg::ST_ADD: begin
        rc.add = 1'b1;
        if (final_q) begin
          state_d = sha1_pkg::ST_EMIT;
        end else if (last_pend_q) begin
          state_d = sha1_pkg::ST_PAD;
        end else begin
          state_d = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_PAD: begin
        if (!pad_first_q && pos_q == sha1_pkg::LEN_POS) begin
          sc.wr_len = 1'b1;
          pos_d     = '0;
          final_d   = 1'b1;
          rc.load   = 1'b1;
          state_d   = sha1_pkg::ST_ROUND;
        end else begin
          sc.wr_byte  = 1'b1;
          sc.byte_val = pad_first_q ? sha1_pkg::PAD_BYTE : sha1_pkg::ZERO_BYTE;
          pad_first_d = 1'b0;
          pos_d       = pos_q + 6'd1;
          if (pos_q == sha1_pkg::FULL_POS) begin
            rc.load = 1'b1;
            state_d = sha1_pkg::ST_ROUND;
          end
        end
      end
      sha1_pkg::ST_EMIT: begin
        if (!out_valid_q || dig_o.ready) begin
          emit        = 1'b1;
          rc.reinit   = 1'b1;
          len_d       = '0;
          final_d     = 1'b0;
          last_pend_d = 1'b0;
          state_d     = sha1_pkg::ST_IDLE;
        end
      end
      default: state_d = sha1_pkg::ST_IDLE;
    endcase
  end

  // digest output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (dig_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      digest_q <= chain;
    end
  end

  assign dig_o.valid        = out_valid_q;
  assign dig_o.digest_word0 = digest_q[0];
  assign dig_o.digest_word1 = digest_q[1];
  assign dig_o.digest_word2 = digest_q[2];
  assign dig_o.digest_word3 = digest_q[3];
  assign dig_o.digest_word4 = digest_q[4];

  // the last round always hands over to the chain add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1_pkg::ST_ROUND && rnd_q == sha1_pkg::LAST_ROUND)
      |=> state_q == sha1_pkg::ST_ADD)
    else $error("round loop did not end in chain add");

  // a new digest only appears out of the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == sha1_pkg::ST_EMIT)
    else $error("digest raised outside emit");

  // the final block is only compressed for a message that has ended
  assert property (@(posedge clk_i) disable iff (!rst_ni) final_q |-> last_pend_q)
    else $error("final block without message end");

  // rounds never start from an idle beat unless the block was just filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1_pkg::ST_IDLE && state_d == sha1_pkg::ST_ROUND)
      |-> pos_q == sha1_pkg::FULL_POS)
    else $error("compression started on a partial block");

endmodule

/* bench/tb_sha1_hash_engine.sv */
// self-checking testbench for the sha-1 hash engine: directed table, random messages, stalls
module tb_sha1_hash_engine;
  timeunit 1ns;
  timeprecision 1ps;

  // five digest words, index 0 is h0
  typedef logic [4:0][31:0] digest_t;

  // one row of the directed table
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       known;
    digest_t    want;
  } stim_row_t;

  localparam digest_t SHA_INIT_WORDS = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                        32'hEFCDAB89, 32'h67452301};
  localparam logic [3:0][31:0] ROUND_ADD = {32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1,
                                            32'h5A827999};
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_SLOT = 6'd56;

  // digest of the empty message
  localparam digest_t EMPTY_DIGEST = {32'hAFD80709, 32'h95601890, 32'h3255BFEF,
                                      32'h5E6B4B0D, 32'hDA39A3EE};

  localparam int unsigned ITEM_TARGET  = 1150;
  localparam int unsigned MIN_MESSAGES = 20;
  localparam int unsigned LONG_HOLD    = 500;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned TAIL_CYCLES  = 300;
  localparam int          N_DIRECTED   = 13;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},            // idle beat straight after reset
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
    '{8'hFF, 1'b0, 1'b1, 1'b0, '0},            // empty again, data bits high
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b0, '0},            // byte carrying the end mark
    '{8'h00, 1'b1, 1'b1, 1'b0, '0},            // lone zero byte
    '{8'hFF, 1'b1, 1'b1, 1'b0, '0},            // lone all-ones byte
    '{8'h80, 1'b1, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b0, 1'b0, '0},            // idle beat inside a message
    '{8'h7F, 1'b1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b0, '0},            // end mark with no byte after data
    '{8'h01, 1'b1, 1'b1, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  sha1_in_if  msg_if ();
  sha1_out_if dig_if ();

  sha1_hash_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .dig_o  (dig_if)
  );

  // hash model state
  digest_t     chain_h;
  logic [31:0] blk_w [16];
  logic [63:0] msg_bits;
  logic [5:0]  blk_pos;

  digest_t pending_digests [$];

  int unsigned mismatches      = 0;
  int unsigned digests_checked = 0;
  int unsigned items_fed       = 0;
  int unsigned bytes_fed       = 0;
  int unsigned messages_fed    = 0;
  int unsigned longest_msg     = 0;
  int unsigned holds_done      = 0;
  int unsigned drains_done     = 0;
  int unsigned burst_left      = 0;
  bit          steady_send     = 1'b0;
  bit          hold_toggle     = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] rol32(logic [31:0] x, int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void restart_message();
    chain_h  = SHA_INIT_WORDS;
    msg_bits = '0;
    blk_pos  = '0;
  endfunction

  // 80 rounds over the current block, then fold into the chain
  function automatic void compress_block();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, f, tmp;
    for (int i = 0; i < 80; i++) begin
      if (i < 16) begin
        sched[i] = blk_w[i];
      end else begin
        sched[i] = rol32(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
      end
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
      end else if (i < 40 || i >= 60) begin
        f = b ^ c ^ d;
      end else begin
        f = (b & c) | (b & d) | (c & d);
      end
      tmp = rol32(a, 5) + f + e + ROUND_ADD[i / 20] + sched[i];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = tmp;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // pack one byte big-endian, compress when the block is full
  function automatic void absorb_byte(logic [7:0] v);
    logic [1:0] lane;
    lane = blk_pos[1:0];
    if (lane == 2'd0) begin
      blk_w[blk_pos[5:2]] = {v, 24'h000000};
    end else begin
      blk_w[blk_pos[5:2]][(3 - lane) * 8 +: 8] = v;
    end
    if (blk_pos == 6'd63) begin
      blk_pos = '0;
      compress_block();
    end else begin
      blk_pos++;
    end
  endfunction

  // one accepted beat; returns 1 with the digest when the message ends
  function automatic bit hash_beat(input logic [7:0] d, input logic p, input logic l,
                                   output digest_t dg);
    dg = '0;
    if (p) begin
      absorb_byte(d);
      msg_bits += 64'd8;
    end
    if (!l) begin
      return 1'b0;
    end
    absorb_byte(PAD_MARK);
    while (blk_pos != LEN_SLOT) begin
      absorb_byte(8'h00);
    end
    blk_w[14] = msg_bits[63:32];
    blk_w[15] = msg_bits[31:0];
    compress_block();
    dg = chain_h;
    restart_message();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 50) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // offer one beat in bursts, with gaps unless sending steadily, wait for it to be taken, then predict
  task automatic send_beat(input logic [7:0] d, input logic p, input logic l,
                           input bit use_known = 1'b0, input digest_t known = '0);
    int unsigned gap;
    digest_t     dg;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if (!steady_send) begin
        gap = $urandom_range(1, 8);
        msg_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    msg_if.valid        <= 1'b1;
    msg_if.data_byte    <= d;
    msg_if.byte_present <= p;
    msg_if.last_byte    <= l;
    do @(posedge clk_i); while (!msg_if.ready);
    burst_left--;
    if (p || l) begin
      items_fed++;
    end
    if (p) begin
      bytes_fed++;
    end
    if (hash_beat(d, p, l, dg)) begin
      pending_digests.push_back(use_known ? known : dg);
    end
  endtask

  // one message of random bytes, with the odd idle beat mixed in
  task automatic send_message(int unsigned n_bytes);
    bit empty_tail;
    empty_tail = (n_bytes == 0) || ($urandom_range(0, 5) == 0);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1, !empty_tail && i == n_bytes - 1);
    end
    if (empty_tail) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    messages_fed++;
    if (n_bytes > longest_msg) begin
      longest_msg = n_bytes;
    end
  endtask

  // wait, with a limit, until every pending digest has come out
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    while (pending_digests.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // receiver: windows of steady, random and patterned ready, plus requested hold-offs
  initial begin : digest_sink
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned mode;
    logic [7:0]  mask;
    bit          seen_toggle;
    mode_left   = 0;
    hold_left   = 0;
    mode        = 0;
    mask        = 8'hFF;
    seen_toggle = 1'b0;
    dig_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = LONG_HOLD;
        holds_done++;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 200);
        mask      = 8'($urandom_range(1, 255));
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        dig_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: dig_if.ready <= 1'b1;
          1: dig_if.ready <= 1'($urandom_range(0, 1));
          2: begin
            mask = {mask[6:0], mask[7]};
            dig_if.ready <= mask[0];
          end
          default: dig_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // compare every taken digest with the oldest prediction
  always @(posedge clk_i) begin : digest_check
    digest_t got;
    digest_t want;
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      got = {dig_if.digest_word4, dig_if.digest_word3, dig_if.digest_word2,
             dig_if.digest_word1, dig_if.digest_word0};
      if (pending_digests.size() == 0) begin
        report_mismatch($sformatf("digest %08h... with none pending", got[0]));
      end else begin
        want = pending_digests.pop_front();
        digests_checked++;
        for (int k = 0; k < 5; k++) begin
          if (got[k] !== want[k]) begin
            report_mismatch($sformatf("digest_word%0d got %08h want %08h",
                                      k, got[k], want[k]));
          end
        end
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int unsigned msg_len;
    int unsigned pick;
    rst_ni              <= 1'b0;
    msg_if.valid        <= 1'b0;
    msg_if.data_byte    <= 8'h00;
    msg_if.byte_present <= 1'b0;
    msg_if.last_byte    <= 1'b0;
    restart_message();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_beat(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].present, DIRECTED_ROWS[r].last,
                DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].want);
    end

    // random messages, mostly short, many around the padding boundaries
    while (items_fed < ITEM_TARGET || messages_fed < MIN_MESSAGES) begin
      if (messages_fed == 8) begin
        // long receiver hold-off while messages keep coming back to back
        hold_toggle <= ~hold_toggle;
        steady_send = 1'b1;
        for (int m = 0; m < 4; m++) begin
          send_message($urandom_range(8, 20));
        end
      end
      if (messages_fed == 14 && drains_done == 0) begin
        // sender pause until the engine is empty
        msg_if.valid <= 1'b0;
        burst_left = 0;
        wait_drained();
        drains_done++;
        @(posedge clk_i);
      end
      steady_send = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        msg_len = $urandom_range(0, 12);
      end else if (pick < 7) begin
        msg_len = $urandom_range(52, 66);
      end else if (pick < 8) begin
        msg_len = $urandom_range(116, 129);
      end else begin
        msg_len = $urandom_range(0, 160);
      end
      send_message(msg_len);
    end

    msg_if.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_digests.size() != 0) begin
      report_mismatch($sformatf("%0d digests never came out", pending_digests.size()));
    end

    $display("hashed %0d messages, %0d bytes, longest %0d bytes; %0d digests compared",
             messages_fed, bytes_fed, longest_msg, digests_checked);
    $display("receiver hold-offs %0d, sender drain pauses %0d, mismatches %0d",
             holds_done, drains_done, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sha1_hash_engine.f */
sv/sha1_pkg.sv
sv/sha1_if.sv
sv/sha1_sched.sv
sv/sha1_round.sv
sv/sha1_hash_engine.sv
bench/tb_sha1_hash_engine.sv
